@@ design/fft_pkg.sv @@
`timescale 1ns / 1ps

package fft_pkg;

  localparam int LOG_POINTS  = 10;
  localparam int POINTS      = 1 << LOG_POINTS;
  localparam int HALF_POINTS = POINTS / 2;
  localparam int SAMPLE_BITS = 16;
  localparam int BIN_BITS    = SAMPLE_BITS + 1 + LOG_POINTS;
  localparam int TW_BITS     = 17;
  localparam int TW_FRAC     = 15;
  localparam int STAGE_W     = $clog2(LOG_POINTS + 1);

  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_BR_RD_I,
    ST_BR_RD_R,
    ST_BR_WR_I,
    ST_BR_WR_R,
    ST_BF_RD_A,
    ST_BF_RD_B,
    ST_BF_M1,
    ST_BF_M2,
    ST_BF_M3,
    ST_BF_WR_A,
    ST_BF_WR_B
  } state_e;

  typedef struct packed {
    logic ld;
    logic mul2;
    logic fin;
  } bfly_ctrl_t;

  typedef logic signed [TW_BITS-1:0] tw_word_t;
  typedef tw_word_t [HALF_POINTS-1:0] tw_tab_t;

  function automatic logic [63:0] sine_q30(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 210;
    t  = Q30_ONE - ((x2 * t) >> 30) / 156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic tw_word_t sine_q15(logic [63:0] arg);
    logic [63:0] x;
    logic [63:0] r;
    x = (arg * TWO_PI_Q30 + (64'd1 << 31)) >> 32;
    r = sine_q30(x);
    r = (r + (64'd1 << 14)) >> 15;
    return tw_word_t'(r[TW_BITS-1:0]);
  endfunction

  function automatic tw_tab_t build_cos();
    tw_tab_t tab;
    logic [63:0] p;
    for (int k = 0; k < HALF_POINTS; k++) begin
      p = 64'(k) << (32 - LOG_POINTS);
      if (p <= Q30_ONE) tab[k] = sine_q15(Q30_ONE - p);
      else              tab[k] = -sine_q15(p - Q30_ONE);
    end
    return tab;
  endfunction

  function automatic tw_tab_t build_sin();
    tw_tab_t tab;
    logic [63:0] p;
    for (int k = 0; k < HALF_POINTS; k++) begin
      p = 64'(k) << (32 - LOG_POINTS);
      if (p <= Q30_ONE) tab[k] = sine_q15(p);
      else              tab[k] = sine_q15((64'd1 << 31) - p);
    end
    return tab;
  endfunction

  localparam tw_tab_t TW_COS = build_cos();
  localparam tw_tab_t TW_SIN = build_sin();

  function automatic logic [LOG_POINTS-1:0] bit_rev(logic [LOG_POINTS-1:0] v);
    logic [LOG_POINTS-1:0] r;
    for (int b = 0; b < LOG_POINTS; b++) r[LOG_POINTS-1-b] = v[b];
    return r;
  endfunction

endpackage

@@ design/fft_ram.sv @@
`timescale 1ns / 1ps

module fft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/fft_bfly.sv @@
`timescale 1ns / 1ps

module fft_bfly (
  input  logic                                   clk_i,
  input  fft_pkg::bfly_ctrl_t                    ctrl_i,
  input  logic signed [fft_pkg::BIN_BITS-1:0]    ar_i,
  input  logic signed [fft_pkg::BIN_BITS-1:0]    ai_i,
  input  logic signed [fft_pkg::BIN_BITS-1:0]    br_i,
  input  logic signed [fft_pkg::BIN_BITS-1:0]    bi_i,
  input  logic signed [fft_pkg::TW_BITS-1:0]     cos_i,
  input  logic signed [fft_pkg::TW_BITS-1:0]     sin_i,
  output logic signed [fft_pkg::BIN_BITS-1:0]    ar_o,
  output logic signed [fft_pkg::BIN_BITS-1:0]    ai_o,
  output logic signed [fft_pkg::BIN_BITS-1:0]    br_o,
  output logic signed [fft_pkg::BIN_BITS-1:0]    bi_o
);
  import fft_pkg::*;

  localparam int PW = BIN_BITS + TW_BITS;
  localparam logic signed [PW:0] RND = (PW+1)'(1) <<< (TW_FRAC - 1);

  logic signed [BIN_BITS-1:0] ur_q, ui_q, br_q, bi_q, vr_q, vi_q;
  logic signed [TW_BITS-1:0]  c_q, s_q;
  logic signed [PW-1:0]       p0_q, p1_q, p2_q, p3_q;
  logic signed [PW:0]         sum_r, sum_i;

  assign sum_r = PW'(p0_q) + PW'(p1_q) + RND;
  assign sum_i = (PW+1)'(p2_q) - (PW+1)'(p3_q) + RND;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld) begin
      ur_q <= ar_i;
      ui_q <= ai_i;
      br_q <= br_i;
      bi_q <= bi_i;
      c_q  <= cos_i;
      s_q  <= sin_i;
      p0_q <= PW'(br_i) * PW'(cos_i);
      p1_q <= PW'(bi_i) * PW'(sin_i);
    end
    if (ctrl_i.mul2) begin
      vr_q <= sum_r[TW_FRAC +: BIN_BITS];
      p2_q <= PW'(bi_q) * PW'(c_q);
      p3_q <= PW'(br_q) * PW'(s_q);
    end
    if (ctrl_i.fin) vi_q <= sum_i[TW_FRAC +: BIN_BITS];
  end

  assign ar_o = ur_q + vr_q;
  assign ai_o = ui_q + vi_q;
  assign br_o = ur_q - vr_q;
  assign bi_o = ui_q - vi_q;

endmodule

@@ design/radix2_fft_engine.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake                       payload
// command   in         start_i & !busy_o               opcode_i index_i sample_re_i sample_im_i
// result    out        res_valid_o, one cycle, no stall bin_re_o bin_im_o done_res_o
// A write beat leaves the engine idle; a read beat's result is registered from the memory's read output.
// A start beat first swaps each sample with its bit-reversed partner (read both, write both),
// then runs the butterflies stage by stage (read A, read B, multiply steps, write A, write B),
// paced by the single read and write port of the sample memory; done follows the last write.
// Reset clears control state only; the sample memory holds no reset value.
// The receiver cannot stall; busy_o stays high until a read or start beat's work is finished.

module radix2_fft_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [1:0]                           opcode_i,
  input  logic [9:0]                           index_i,
  input  logic signed [fft_pkg::SAMPLE_BITS-1:0] sample_re_i,
  input  logic signed [fft_pkg::SAMPLE_BITS-1:0] sample_im_i,
  output logic                                 res_valid_o,
  output logic signed [fft_pkg::BIN_BITS-1:0]  bin_re_o,
  output logic signed [fft_pkg::BIN_BITS-1:0]  bin_im_o,
  output logic                                 done_res_o
);
  import fft_pkg::*;

  localparam int AW = LOG_POINTS;
  localparam int KW = LOG_POINTS - 1;
  localparam int DW = 2 * BIN_BITS;

  state_e state_q, state_d;
  logic [AW-1:0] i_q, i_d;
  logic [KW-1:0] n_q, n_d;
  logic [STAGE_W-1:0] s_q, s_d;
  logic valid_q, valid_d, done_q, done_d;
  logic signed [BIN_BITS-1:0] ore_q, ore_d, oim_q, oim_d;
  logic [DW-1:0] hold_q, hold_d;
  logic signed [TW_BITS-1:0] c_q, sn_q;

  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [AW-1:0] rev, lowmask, a_addr, b_addr;
  logic [KW-1:0] k;
  logic [KW-1:0] last_n;
  bfly_ctrl_t bctrl;
  logic signed [BIN_BITS-1:0] nar, nai, nbr, nbi;

  assign rev     = bit_rev(i_q);
  assign lowmask = (AW'(1) << s_q) - AW'(1);
  assign a_addr  = ((AW'(n_q) & ~lowmask) << 1) | (AW'(n_q) & lowmask);
  assign b_addr  = a_addr | (AW'(1) << s_q);
  assign k       = KW'((AW'(n_q) & lowmask) << (STAGE_W'(KW) - s_q));
  assign last_n  = '1;

  fft_ram #(.WIDTH(DW), .DEPTH(POINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  fft_bfly u_bfly (
    .clk_i  (clk_i),
    .ctrl_i (bctrl),
    .ar_i   (hold_q[DW-1:BIN_BITS]),
    .ai_i   (hold_q[BIN_BITS-1:0]),
    .br_i   (rdata[DW-1:BIN_BITS]),
    .bi_i   (rdata[BIN_BITS-1:0]),
    .cos_i  (c_q),
    .sin_i  (sn_q),
    .ar_o   (nar),
    .ai_o   (nai),
    .br_o   (nbr),
    .bi_o   (nbi)
  );

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    n_d     = n_q;
    s_d     = s_q;
    valid_d = 1'b0;
    done_d  = done_q;
    ore_d   = ore_q;
    oim_d   = oim_q;
    hold_d  = hold_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = a_addr;
    raddr   = a_addr;
    wdata   = {nar, nai};
    bctrl   = '0;
    unique case (state_q)
      ST_IDLE: begin
        waddr = index_i;
        raddr = index_i;
        wdata = {BIN_BITS'(sample_re_i), BIN_BITS'(sample_im_i)};
        if (start_i) begin
          unique case (opcode_i)
            OP_WRITE: we = 1'b1;
            OP_READ: begin
              re      = 1'b1;
              state_d = ST_RD_OUT;
            end
            OP_START: begin
              i_d     = '0;
              state_d = ST_BR_RD_I;
            end
            default: ;
          endcase
        end
      end
      ST_RD_OUT: begin
        valid_d = 1'b1;
        done_d  = 1'b0;
        ore_d   = rdata[DW-1:BIN_BITS];
        oim_d   = rdata[BIN_BITS-1:0];
        state_d = ST_IDLE;
      end
      ST_BR_RD_I: begin
        raddr = i_q;
        if (i_q < rev) begin
          re      = 1'b1;
          state_d = ST_BR_RD_R;
        end else if (i_q == '1) begin
          n_d     = '0;
          s_d     = '0;
          state_d = ST_BF_RD_A;
        end else begin
          i_d = i_q + AW'(1);
        end
      end
      ST_BR_RD_R: begin
        raddr   = rev;
        re      = 1'b1;
        hold_d  = rdata;
        state_d = ST_BR_WR_I;
      end
      ST_BR_WR_I: begin
        we      = 1'b1;
        waddr   = i_q;
        wdata   = rdata;
        state_d = ST_BR_WR_R;
      end
      ST_BR_WR_R: begin
        we      = 1'b1;
        waddr   = rev;
        wdata   = hold_q;
        i_d     = i_q + AW'(1);
        state_d = ST_BR_RD_I;
      end
      ST_BF_RD_A: begin
        re      = 1'b1;
        raddr   = a_addr;
        state_d = ST_BF_RD_B;
      end
      ST_BF_RD_B: begin
        re      = 1'b1;
        raddr   = b_addr;
        hold_d  = rdata;
        state_d = ST_BF_M1;
      end
      ST_BF_M1: begin
        bctrl.ld = 1'b1;
        state_d  = ST_BF_M2;
      end
      ST_BF_M2: begin
        bctrl.mul2 = 1'b1;
        state_d    = ST_BF_M3;
      end
      ST_BF_M3: begin
        bctrl.fin = 1'b1;
        state_d   = ST_BF_WR_A;
      end
      ST_BF_WR_A: begin
        we      = 1'b1;
        waddr   = a_addr;
        wdata   = {nar, nai};
        state_d = ST_BF_WR_B;
      end
      ST_BF_WR_B: begin
        we      = 1'b1;
        waddr   = b_addr;
        wdata   = {nbr, nbi};
        state_d = ST_BF_RD_A;
        n_d     = n_q + KW'(1);
        if (n_q == last_n) begin
          s_d = s_q + STAGE_W'(1);
          if (s_q == STAGE_W'(LOG_POINTS - 1)) begin
            valid_d = 1'b1;
            done_d  = 1'b1;
            ore_d   = '0;
            oim_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      i_q     <= '0;
      n_q     <= '0;
      s_q     <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      i_q     <= i_d;
      n_q     <= n_d;
      s_q     <= s_d;
    end
  end

  always_ff @(posedge clk_i) begin
    done_q <= done_d;
    ore_q  <= ore_d;
    oim_q  <= oim_d;
    hold_q <= hold_d;
    c_q    <= TW_COS[k];
    sn_q   <= TW_SIN[k];
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = valid_q;
  assign bin_re_o    = ore_q;
  assign bin_im_o    = oim_q;
  assign done_res_o  = done_q;

endmodule

@@ design/fft_checker.sv @@
`timescale 1ns / 1ps

module fft_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic [1:0]                          opcode_i,
  input logic                                res_valid_o,
  input logic signed [fft_pkg::BIN_BITS-1:0] bin_re_o,
  input logic signed [fft_pkg::BIN_BITS-1:0] bin_im_o,
  input logic                                done_res_o
);
  import fft_pkg::*;

  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (opcode_i == OP_WRITE || opcode_i == OP_NONE)
      |=> !busy_o && !res_valid_o)
    else $error("write beat left the engine busy");

  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && opcode_i == OP_READ
      |=> busy_o ##1 (res_valid_o && !done_res_o && !busy_o))
    else $error("read result late or mismarked");

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o)
    else $error("result shown while busy");

  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result repeated");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && done_res_o |-> bin_re_o == '0 && bin_im_o == '0)
    else $error("done beat carries data");

endmodule

bind radix2_fft_engine fft_checker u_fft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .opcode_i    (opcode_i),
  .res_valid_o (res_valid_o),
  .bin_re_o    (bin_re_o),
  .bin_im_o    (bin_im_o),
  .done_res_o  (done_res_o)
);
